>>> rtl/primal_dual_engine_dispatcher_macros.svh
// Assertion macros for the primal-dual engine dispatcher.
`ifndef PRIMAL_DUAL_ENGINE_DISPATCHER_MACROS_SVH
`define PRIMAL_DUAL_ENGINE_DISPATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define PDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define PDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pde_pkg.sv
// Shared types, constants and sigmoid table builder for the dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package pde_pkg;

  localparam int unsigned SIGMOID_ENTRIES_DEF = 256;
  localparam int unsigned DUAL_WIDTH_DEF      = 20;
  localparam int unsigned QUEUE_DEPTH_DEF     = 2;

  localparam int unsigned VAL_W       = 16;   // Q0.16 values and loads
  localparam int unsigned SUM_W       = 17;   // row + col
  localparam int unsigned DIV_STEPS   = 16;   // quotient bits of the load share
  localparam int unsigned ARG_LIMIT   = 524288; // 8.0 in Q4.16
  localparam int unsigned ARG_W       = 20;   // holds ARG_LIMIT
  localparam int unsigned SPAN_SHIFT  = 20;   // log2 of 2*ARG_LIMIT
  localparam int unsigned SCALE_SHIFT = 12;   // Q4.12 scale
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [VAL_W-1:0] UPPER_BOUND_RST = 16'd45875;
  localparam logic [VAL_W-1:0] LOWER_BOUND_RST = 16'd19661;
  localparam logic [VAL_W-1:0] STEP_RATE_RST   = 16'd1311;
  localparam logic [VAL_W-1:0] SIG_SCALE_RST   = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_BOUND,
    REG_LOWER_BOUND,
    REG_STEP_RATE,
    REG_SIG_SCALE
  } pde_reg_e;

  typedef enum logic [1:0] {
    KIND_NORMAL,   // both loads present, divide
    KIND_NO_LOAD,  // both loads zero, share is zero
    KIND_ROW_ONLY  // column idle, share saturates
  } pde_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_INDEX,
    ST_LOOKUP,
    ST_STEP,
    ST_APPLY
  } pde_state_e;

  typedef struct packed {
    logic [VAL_W-1:0] upper_bound;
    logic [VAL_W-1:0] lower_bound;
    logic [VAL_W-1:0] step_rate;
    logic [VAL_W-1:0] sig_scale;
  } pde_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] score;
    logic [VAL_W-1:0] row_load;
    logic [SUM_W-1:0] load_sum;
    pde_kind_e        kind;
  } pde_item_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } pde_status_t;

  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

  // unsigned 64-bit quotient by shift and subtract; elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q0.32, f in Q0.16 with 0 <= f <= 1.0; elaboration only
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = ONE_Q32;
    term = ONE_Q32;
    for (int k = 1; k <= 16; k++) begin
      term = div_u64(term * f, 64'(k) << 16);
      if ((k & 1) != 0) acc = acc - term;
      else              acc = acc + term;
    end
    return acc;
  endfunction

  // exp(-m) in Q0.32, m in Q4.16 up to 8.0
  function automatic logic [63:0] exp_neg(input logic [63:0] m);
    logic [63:0] e;
    logic [63:0] em1;
    logic [63:0] n;
    e   = exp_neg_frac(m & 64'hFFFF);
    em1 = exp_neg_frac(64'd65536);
    n   = m >> 16;
    for (int i = 0; i < 8; i++) begin
      if (64'(i) < n) e = (e * em1) >> 32;
    end
    return e;
  endfunction

  // sigmoid(c) in Q0.16, c in Q4.16, rounded and saturated
  function automatic logic [VAL_W-1:0] sigmoid_q16(input longint c);
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    mag = (c < 0) ? 64'(-c) : 64'(c);
    if (mag > 64'(ARG_LIMIT)) mag = 64'(ARG_LIMIT);
    e   = exp_neg(mag);
    den = ONE_Q32 + e;
    if (c >= 0) s = div_u64((64'd1 << 48) + (den >> 1), den);
    else        s = div_u64((e << 16) + (den >> 1), den);
    if (s > 64'd65535) s = 64'd65535;
    return s[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/primal_dual_engine_dispatcher.sv
// Top level of the primal-dual engine dispatcher: config registers and wiring.
//
// Usage: one request transaction on the slave stream carries a score and the
// current row and column engine loads; exactly one result transaction on the
// master stream returns the routing decision and the threshold it was made
// against. Results leave in request order.
// Flow: the front end registers the request, a short queue passes it to the
// back end, whose restoring divider (one quotient bit a cycle) forms the row
// share; then come scaling, table index, table read, step products and the
// dual write-back, each a state of its own. The back end takes a new request
// only once it has finished the last one. When both loads are zero or the
// column load is zero the divider is skipped. The front end and queue keep
// taking requests while the back end is busy or a result waits at the output
// register; when the receiver stalls, the back end holds its finished request
// until the output register frees, then the queue and finally s_axis_tready
// back up.
// Reset clears both duals to zero, loads the default targets, step rate and
// sigmoid scale, and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "primal_dual_engine_dispatcher_macros.svh"

module primal_dual_engine_dispatcher #(
  parameter int unsigned SIGMOID_ENTRIES = pde_pkg::SIGMOID_ENTRIES_DEF,
  parameter int unsigned DUAL_WIDTH      = pde_pkg::DUAL_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH     = pde_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // request stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [15:0] score, [31:16] row_load, [47:32] col_load
  input  wire logic [pde_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [0] column select, [16:1] threshold, [23:17] zero
  output logic      [pde_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [pde_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pde_pkg::VAL_W-1:0]            cfg_data_i
);

  localparam int unsigned PAD_W = pde_pkg::OUT_TDATA_W - pde_pkg::VAL_W - 1;

  pde_pkg::pde_cfg_t    cfg_q, cfg_d;
  pde_pkg::pde_item_t   front_item, queue_item;
  pde_pkg::pde_status_t bk_status;
  logic                 q_push, q_full, q_valid;
  logic                 res_choose;
  logic [pde_pkg::VAL_W-1:0] res_theta;

  // register file; a write lands at once; host must write with nothing in flight
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pde_pkg::pde_reg_e'(cfg_idx_i))
        pde_pkg::REG_UPPER_BOUND: cfg_d.upper_bound = cfg_data_i;
        pde_pkg::REG_LOWER_BOUND: cfg_d.lower_bound = cfg_data_i;
        pde_pkg::REG_STEP_RATE:   cfg_d.step_rate   = cfg_data_i;
        pde_pkg::REG_SIG_SCALE:   cfg_d.sig_scale   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_bound <= pde_pkg::UPPER_BOUND_RST;
      cfg_q.lower_bound <= pde_pkg::LOWER_BOUND_RST;
      cfg_q.step_rate   <= pde_pkg::STEP_RATE_RST;
      cfg_q.sig_scale   <= pde_pkg::SIG_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (front_item)
  );

  pde_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (bk_status.pop),
    .item_o (queue_item)
  );

  pde_back #(
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES),
    .DUAL_WIDTH     (DUAL_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (queue_item),
    .status_o  (bk_status),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_choose_o(res_choose),
    .m_theta_o (res_theta)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res_theta, res_choose};

  // back end only pops a queue that holds a transaction
  `PDE_ASSERT_NOW(a_pop_nonempty, bk_status.pop, q_valid, "pop from empty queue")
  // front end never pushes into a full queue
  `PDE_ASSERT_NOW(a_push_not_full, q_push, !q_full, "push into full queue")
  // a result only appears after the back end has worked on a request
  `PDE_ASSERT_NEXT(a_result_from_work, !m_axis_tvalid && !bk_status.busy,
                   !m_axis_tvalid, "result without a request in flight")

endmodule

`default_nettype wire

>>> rtl/pde_front.sv
// Front end: accepts requests, sums the loads and classifies the share case.
`timescale 1ns / 1ps
`default_nettype none

module pde_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [pde_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire logic                                q_full_i,
  output logic                                     q_push_o,
  output pde_pkg::pde_item_t                       q_item_o
);

  logic               vld_q, vld_d;
  pde_pkg::pde_item_t item_q, item_d;
  logic [pde_pkg::VAL_W-1:0] col_load;
  logic               take;

  assign s_axis_tready = !vld_q || !q_full_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign q_push_o      = vld_q && !q_full_i;
  assign q_item_o      = item_q;

  always_comb begin
    item_d          = item_q;
    col_load        = s_axis_tdata[47:32];
    item_d.score    = s_axis_tdata[15:0];
    item_d.row_load = s_axis_tdata[31:16];
    item_d.load_sum = {1'b0, s_axis_tdata[31:16]} + {1'b0, col_load};
    if (item_d.load_sum == '0)   item_d.kind = pde_pkg::KIND_NO_LOAD;
    else if (col_load == '0)     item_d.kind = pde_pkg::KIND_ROW_ONLY;
    else                         item_d.kind = pde_pkg::KIND_NORMAL;
  end

  always_comb begin
    vld_d = vld_q;
    if (take)          vld_d = 1'b1;
    else if (q_push_o) vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pde_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module pde_queue #(
  parameter int unsigned QUEUE_DEPTH = pde_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  pde_pkg::pde_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output pde_pkg::pde_item_t item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pde_pkg::pde_item_t slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pde_sig_rom.sv
// Sigmoid threshold table, Q0.16, built at elaboration; registered read.
`timescale 1ns / 1ps
`default_nettype none

module pde_sig_rom #(
  parameter int unsigned SIGMOID_ENTRIES = pde_pkg::SIGMOID_ENTRIES_DEF,
  localparam int unsigned IDX_W = $clog2(SIGMOID_ENTRIES)
) (
  input  wire logic                         clk_i,
  input  wire logic [IDX_W-1:0]             idx_i,
  output logic      [pde_pkg::VAL_W-1:0]    theta_o
);

  logic [pde_pkg::VAL_W-1:0] rom_w [SIGMOID_ENTRIES];

  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_entry
    // bin centre across [-8, 8)
    localparam longint Center =
      (longint'(2 * g + 1) * longint'(pde_pkg::ARG_LIMIT)) / longint'(SIGMOID_ENTRIES)
      - longint'(pde_pkg::ARG_LIMIT);
    localparam logic [pde_pkg::VAL_W-1:0] Value = pde_pkg::sigmoid_q16(Center);
    assign rom_w[g] = Value;
  end

  always_ff @(posedge clk_i) begin
    theta_o <= rom_w[idx_i];
  end

endmodule

`default_nettype wire

>>> rtl/pde_back.sv
// Back end: load-share divider, threshold lookup, decision and dual update.
`timescale 1ns / 1ps
`default_nettype none

module pde_back #(
  parameter int unsigned SIGMOID_ENTRIES = pde_pkg::SIGMOID_ENTRIES_DEF,
  parameter int unsigned DUAL_WIDTH      = pde_pkg::DUAL_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  pde_pkg::pde_cfg_t                    cfg_i,
  input  wire logic                            q_valid_i,
  input  pde_pkg::pde_item_t                   q_item_i,
  output pde_pkg::pde_status_t                 status_o,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic                                 m_choose_o,
  output logic      [pde_pkg::VAL_W-1:0]       m_theta_o
);

  localparam int unsigned VW    = pde_pkg::VAL_W;
  localparam int unsigned IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned PRD_W = DUAL_WIDTH + VW;
  localparam int unsigned SCL_W = PRD_W - pde_pkg::SCALE_SHIFT;
  localparam int unsigned OFS_W = pde_pkg::ARG_W + 1;
  localparam int unsigned IXP_W = OFS_W + IDX_W + 1;
  localparam int unsigned IXF_W = IXP_W - pde_pkg::SPAN_SHIFT;
  localparam int unsigned CNT_W = $clog2(pde_pkg::DIV_STEPS);
  localparam int unsigned STP_W = 2 * VW;

  pde_pkg::pde_state_e state_q, state_d;

  // control
  logic load_item, div_step, do_scale, do_index, do_step, do_apply, out_free;

  // request payload
  logic [VW-1:0]                 score_q;
  logic [pde_pkg::SUM_W-1:0]     sum_q;
  logic [pde_pkg::SUM_W-1:0]     rem_q, rem_d;
  logic [VW-1:0]                 rho_q, rho_d;
  logic [CNT_W-1:0]              cnt_q;
  logic [pde_pkg::SUM_W:0]       rem_shift;
  logic                          q_bit;

  // threshold path
  logic [DUAL_WIDTH-1:0]         upper_q, lower_q, upper_d, lower_d, diff_mag;
  logic                          neg_q;
  logic [PRD_W-1:0]              prod_q;
  logic [SCL_W-1:0]              scaled;
  logic [pde_pkg::ARG_W-1:0]     arg_mag;
  logic [OFS_W-1:0]              offset;
  logic [IXP_W-1:0]              idx_prod;
  logic [IXF_W-1:0]              idx_full;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [VW-1:0]                 theta;

  // dual step
  logic                          up_inc_q, lo_inc_q, up_inc, lo_inc;
  logic [VW-1:0]                 up_err, lo_err;
  logic [STP_W-1:0]              up_prod_q, lo_prod_q;

  // output register
  logic                          out_valid_q;
  logic                          out_choose_q;
  logic [VW-1:0]                 out_theta_q;

  function automatic logic [DUAL_WIDTH-1:0] step_dual(
    input logic [DUAL_WIDTH-1:0] lam,
    input logic [VW-1:0]         delta,
    input logic                  inc
  );
    logic [DUAL_WIDTH:0]   grown;
    logic [DUAL_WIDTH-1:0] dext;
    logic [DUAL_WIDTH-1:0] res;
    dext  = DUAL_WIDTH'(delta);
    grown = {1'b0, lam} + {1'b0, dext};
    if (inc) res = grown[DUAL_WIDTH] ? '1 : grown[DUAL_WIDTH-1:0];
    else     res = (dext >= lam) ? '0 : lam - dext;
    return res;
  endfunction

  pde_sig_rom #(
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
  ) u_rom (
    .clk_i  (clk_i),
    .idx_i  (idx_q),
    .theta_o(theta)
  );

  assign out_free   = !out_valid_q || m_ready_i;
  assign m_valid_o  = out_valid_q;
  assign m_choose_o = out_choose_q;
  assign m_theta_o  = out_theta_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pde_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.kind == pde_pkg::KIND_NORMAL) ? pde_pkg::ST_DIVIDE
                                                            : pde_pkg::ST_SCALE;
        end
      end
      pde_pkg::ST_DIVIDE: begin
        if (cnt_q == CNT_W'(pde_pkg::DIV_STEPS - 1)) state_d = pde_pkg::ST_SCALE;
      end
      pde_pkg::ST_SCALE:  state_d = pde_pkg::ST_INDEX;
      pde_pkg::ST_INDEX:  state_d = pde_pkg::ST_LOOKUP;
      pde_pkg::ST_LOOKUP: state_d = pde_pkg::ST_STEP;
      pde_pkg::ST_STEP:   state_d = pde_pkg::ST_APPLY;
      pde_pkg::ST_APPLY: begin
        if (out_free) state_d = pde_pkg::ST_IDLE;
      end
      default: state_d = pde_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    load_item = 1'b0;
    div_step  = 1'b0;
    do_scale  = 1'b0;
    do_index  = 1'b0;
    do_step   = 1'b0;
    do_apply  = 1'b0;
    case (state_q)
      pde_pkg::ST_IDLE:   load_item = q_valid_i;
      pde_pkg::ST_DIVIDE: div_step  = 1'b1;
      pde_pkg::ST_SCALE:  do_scale  = 1'b1;
      pde_pkg::ST_INDEX:  do_index  = 1'b1;
      pde_pkg::ST_STEP:   do_step   = 1'b1;
      pde_pkg::ST_APPLY:  do_apply  = out_free;
      default: ;
    endcase
  end

  assign status_o.busy = (state_q != pde_pkg::ST_IDLE);
  assign status_o.pop  = load_item;

  // restoring division: one quotient bit per cycle
  always_comb begin
    rem_shift = {rem_q, 1'b0};
    q_bit     = (rem_shift >= {1'b0, sum_q});
    rem_d     = q_bit ? pde_pkg::SUM_W'(rem_shift - {1'b0, sum_q})
                      : rem_shift[pde_pkg::SUM_W-1:0];
    rho_d     = {rho_q[VW-2:0], q_bit};
  end

  // threshold argument and table index
  always_comb begin
    diff_mag = (lower_q < upper_q) ? upper_q - lower_q : lower_q - upper_q;
    scaled   = prod_q[PRD_W-1:pde_pkg::SCALE_SHIFT];
    arg_mag  = (scaled > SCL_W'(pde_pkg::ARG_LIMIT)) ? pde_pkg::ARG_W'(pde_pkg::ARG_LIMIT)
                                                     : scaled[pde_pkg::ARG_W-1:0];
    offset   = neg_q ? OFS_W'(pde_pkg::ARG_LIMIT) - {1'b0, arg_mag}
                     : OFS_W'(pde_pkg::ARG_LIMIT) + {1'b0, arg_mag};
    idx_prod = IXP_W'(offset) * IXP_W'(SIGMOID_ENTRIES);
    idx_full = idx_prod[IXP_W-1:pde_pkg::SPAN_SHIFT];
    idx_d    = (idx_full > IXF_W'(SIGMOID_ENTRIES - 1)) ? IDX_W'(SIGMOID_ENTRIES - 1)
                                                        : idx_full[IDX_W-1:0];
  end

  // subgradient errors
  always_comb begin
    up_inc  = (rho_q >= cfg_i.upper_bound);
    up_err  = up_inc ? rho_q - cfg_i.upper_bound : cfg_i.upper_bound - rho_q;
    lo_inc  = (cfg_i.lower_bound >= rho_q);
    lo_err  = lo_inc ? cfg_i.lower_bound - rho_q : rho_q - cfg_i.lower_bound;
    upper_d = step_dual(upper_q, up_prod_q[STP_W-1:VW], up_inc_q);
    lower_d = step_dual(lower_q, lo_prod_q[STP_W-1:VW], lo_inc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pde_pkg::ST_IDLE;
      cnt_q       <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_item)     cnt_q <= '0;
      else if (div_step) cnt_q <= cnt_q + 1'b1;
      if (do_apply) begin
        upper_q     <= upper_d;
        lower_q     <= lower_d;
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      score_q <= q_item_i.score;
      sum_q   <= q_item_i.load_sum;
      rem_q   <= q_item_i.row_load[pde_pkg::SUM_W-2:0] == q_item_i.row_load ?
                 {1'b0, q_item_i.row_load} : {1'b0, q_item_i.row_load};
      case (q_item_i.kind)
        pde_pkg::KIND_NO_LOAD:  rho_q <= '0;
        pde_pkg::KIND_ROW_ONLY: rho_q <= '1;
        default:                rho_q <= '0;
      endcase
    end else if (div_step) begin
      rem_q <= rem_d;
      rho_q <= rho_d;
    end
    if (do_scale) begin
      neg_q  <= (lower_q < upper_q);
      prod_q <= PRD_W'(diff_mag) * PRD_W'(cfg_i.sig_scale);
    end
    if (do_index) begin
      idx_q <= idx_d;
    end
    if (do_step) begin
      up_inc_q  <= up_inc;
      lo_inc_q  <= lo_inc;
      up_prod_q <= STP_W'(cfg_i.step_rate) * STP_W'(up_err);
      lo_prod_q <= STP_W'(cfg_i.step_rate) * STP_W'(lo_err);
    end
    if (do_apply) begin
      out_choose_q <= (score_q > theta);
      out_theta_q  <= theta;
    end
  end

endmodule

`default_nettype wire
